// ----- hdl/square_code_transposition_cipher_macros.svh -----
// Assertion macros for the square code transposition cipher.
// Included by the files that check their own logic; depends on nothing.
`ifndef SQUARE_CODE_TRANSPOSITION_CIPHER_MACROS_SVH
`define SQUARE_CODE_TRANSPOSITION_CIPHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCTC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sctc assertion failed");
`define SCTC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sctc assertion failed");
`else
`define SCTC_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define SCTC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- hdl/sctc_pkg.sv -----
// Shared types and constants of the square code transposition cipher.
// Used by the controller, the datapath and the top level.
package sctc_pkg;

	localparam int MAX_LETTERS_DEF = 63;
	localparam int OUT_LIMIT       = 64;
	localparam logic [7:0] PAD_CHAR   = 8'h23;
	localparam logic [7:0] EMPTY_CHAR = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIZE,
		ST_READ,
		ST_LOAD,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic accept;
		logic size;
		logic read;
		logic load;
		logic load_empty;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic walk_last;
		logic out_free;
	} status_t;

endpackage

// ----- hdl/sctc_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// Stands alone; used for the letter store.
module sctc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/sctc_ctrl.sv -----
// Controller state machine of the square code transposition cipher.
// Depends on sctc_pkg; drives the datapath through cmd_t and reads status_t.
module sctc_ctrl import sctc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && in_last) begin
					state_d = ST_SIZE;
				end
			end
			ST_SIZE: begin
				if (st.empty) begin
					state_d = ST_EMPTY;
				end else begin
					cmd.size = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_LOAD;
			end
			ST_LOAD: begin
				if (st.out_free) begin
					cmd.load = 1'b1;
					if (st.walk_last) begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_EMPTY: begin
				if (st.out_free) begin
					cmd.load_empty = 1'b1;
					cmd.clear      = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/sctc_datapath.sv -----
// Datapath of the square code transposition cipher: letter store, grid
// sizing, column walk and output register. Depends on sctc_pkg and sctc_ram.
module sctc_datapath import sctc_pkg::*; #(
	parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output status_t    st,
	input  logic [7:0] char_in,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_char,
	output logic       out_last,
	output logic       no_letters,
	output logic       overflowed
);

	localparam int CW  = $clog2(MAX_LETTERS + 1);
	localparam int AW  = $clog2(MAX_LETTERS > 1 ? MAX_LETTERS : 2);
	localparam int SW  = CW / 2 + 1;
	localparam int LW  = SW + 1;
	localparam int QW  = CW + 2;
	localparam int KW  = $clog2(OUT_LIMIT);

	logic [CW-1:0] count_q;
	logic [SW-1:0] root_q;
	logic [QW-1:0] prod_q;
	logic [QW-1:0] sq_q;
	logic          ovf_q;
	logic [LW-1:0] cols_q, rows_q, col_q, row_q;
	logic [QW-1:0] cell_q;
	logic [KW-1:0] k_q;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_last_q, no_letters_q, overflowed_q;

	logic          is_letter, store_full, do_store, cell_in_text;
	logic [7:0]    lower;
	logic [CW-1:0] count_nx;
	logic [7:0]    rdata;
	logic [7:0]    cell_char;
	logic [LW-1:0] rows_calc;

	assign is_letter  = ((char_in >= 8'h41) && (char_in <= 8'h5A)) ||
	                    ((char_in >= 8'h61) && (char_in <= 8'h7A));
	assign lower      = char_in | 8'h20;
	assign store_full = (count_q == CW'(MAX_LETTERS));
	assign do_store   = cmd.accept && is_letter && !store_full;
	assign count_nx   = count_q + CW'(1);

	assign cell_in_text = (cell_q < QW'(count_q));
	assign cell_char    = cell_in_text ? rdata : PAD_CHAR;
	assign rows_calc    = (QW'(count_q) <= prod_q) ? LW'(root_q) : LW'(root_q) + LW'(1);

	sctc_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LETTERS)
	) u_store (
		.clk  (clk),
		.we   (do_store),
		.waddr(count_q[AW-1:0]),
		.wdata(lower),
		.re   (cmd.read && cell_in_text),
		.raddr(cell_q[AW-1:0]),
		.rdata(rdata)
	);

	// The integer root of the count is kept up to date as letters arrive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			root_q  <= '0;
			prod_q  <= '0;
			sq_q    <= QW'(1);
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			root_q  <= '0;
			prod_q  <= '0;
			sq_q    <= QW'(1);
			ovf_q   <= 1'b0;
		end else if (cmd.accept && is_letter) begin
			if (store_full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_nx;
				if (QW'(count_nx) == sq_q) begin
					root_q <= root_q + SW'(1);
					prod_q <= sq_q + QW'(root_q) + QW'(1);
					sq_q   <= sq_q + QW'({root_q, 1'b0}) + QW'(3);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.size) begin
			cols_q <= LW'(root_q) + LW'(1);
			rows_q <= rows_calc;
			col_q  <= '0;
			row_q  <= '0;
			cell_q <= '0;
			k_q    <= '0;
		end else if (cmd.load) begin
			k_q <= k_q + KW'(1);
			if (row_q == rows_q - LW'(1)) begin
				row_q  <= '0;
				col_q  <= col_q + LW'(1);
				cell_q <= QW'(col_q) + QW'(1);
			end else begin
				row_q  <= row_q + LW'(1);
				cell_q <= cell_q + QW'(cols_q);
			end
		end
	end

	assign st.empty     = (count_q == '0);
	assign st.walk_last = (k_q == KW'(OUT_LIMIT - 1)) ||
	                      ((col_q == cols_q - LW'(1)) && (row_q == rows_q - LW'(1)));
	assign st.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load || cmd.load_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_char_q   <= cell_char;
			out_last_q   <= st.walk_last;
			no_letters_q <= 1'b0;
			overflowed_q <= ovf_q;
		end else if (cmd.load_empty) begin
			out_char_q   <= EMPTY_CHAR;
			out_last_q   <= 1'b1;
			no_letters_q <= 1'b1;
			overflowed_q <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign out_last   = out_last_q;
	assign no_letters = no_letters_q;
	assign overflowed = overflowed_q;

endmodule

// ----- hdl/square_code_transposition_cipher.sv -----
// Top level of the square code transposition cipher.
// Depends on sctc_pkg, sctc_ctrl, sctc_datapath and the assertion macro header.
`include "square_code_transposition_cipher_macros.svh"

// Message bytes enter one per cycle while no cipher bytes are produced; letters
// are folded to lower case and stored, up to MAX_LETTERS of them, and other
// bytes are dropped. The byte with tlast set closes the message: the grid is
// sized, then each cipher byte takes a registered read of the letter memory
// and then a load of the output register, which waits while the output
// stalls, so a message of n letters gives r*c bytes (at most 64).
// A message without letters gives one byte with the empty flag.
// No input is taken while the cipher bytes are produced; the last cipher byte
// may still wait in the output register while the next message loads.
module square_code_transposition_cipher import sctc_pkg::*; #(
	parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_in
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic       m_axis_tlast,
	output logic [1:0] m_axis_tuser    // [0] no_letters, [1] overflowed
);

	cmd_t    cmd;
	status_t st;

	sctc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_last (s_axis_tlast),
		.in_ready(s_axis_tready),
		.st      (st),
		.cmd     (cmd)
	);

	sctc_datapath #(
		.MAX_LETTERS(MAX_LETTERS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.char_in   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.no_letters(m_axis_tuser[0]),
		.overflowed(m_axis_tuser[1])
	);

	`SCTC_ASSERT_SAME(a_load_free, clk, arst_n, cmd.load || cmd.load_empty, st.out_free)
	`SCTC_ASSERT_SAME(a_no_input_walk, clk, arst_n, s_axis_tready, !(cmd.load || cmd.read))
	`SCTC_ASSERT_SAME(a_empty_last, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
	`SCTC_ASSERT_NEXT(a_read_then_load, clk, arst_n, cmd.read, !s_axis_tready && !cmd.read)

endmodule

// ----- test/square_code_transposition_cipher_checker.sv -----
`timescale 1ns / 100ps
// Checker of the square code transposition cipher: it watches both stream ports,
// predicts the cipher bytes of every message and compares them in order.
// Depends on sctc_pkg.
module square_code_transposition_cipher_checker import sctc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_in
	input  logic       s_axis_tlast,
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [7:0] out_char
	input  logic       m_axis_tlast,
	input  logic [1:0] m_axis_tuser,   // [0] no_letters, [1] overflowed
	output int         errors,
	output int         pending
);

	localparam int EXP_DEPTH = 256;

	typedef struct packed {
		logic [7:0] text;
		logic       eom;
		logic       no_letters;
		logic       overflowed;
	} cipher_byte_t;

	cipher_byte_t expect_mem [EXP_DEPTH];
	int           wr_cnt;
	int           rd_cnt;
	cipher_byte_t got_byte;
	cipher_byte_t want_byte;
	logic [7:0]   letters [MAX_LETTERS_DEF];
	int           letter_cnt;
	logic         lost_letters;

	task automatic add_expected(input cipher_byte_t b);
		expect_mem[wr_cnt % EXP_DEPTH] = b;
		wr_cnt++;
	endtask

	task automatic transpose_message(input logic [7:0] raw, input logic eom);
		logic [7:0] ch;
		int         root;
		int         cols;
		int         rows;
		int         total;
		int         k;
		int         pos;
		ch = raw;
		if (raw >= "A" && raw <= "Z") begin
			ch = raw + 8'h20;
		end
		if (ch >= "a" && ch <= "z") begin
			if (letter_cnt < MAX_LETTERS_DEF) begin
				letters[letter_cnt] = ch;
				letter_cnt++;
			end else begin
				lost_letters = 1'b1;
			end
		end
		if (eom) begin
			if (letter_cnt == 0) begin
				add_expected(cipher_byte_t'{EMPTY_CHAR, 1'b1, 1'b1, lost_letters});
			end else begin
				root = 0;
				while ((root + 1) * (root + 1) <= letter_cnt) begin
					root++;
				end
				cols = root + 1;
				rows = (letter_cnt + cols - 1) / cols;
				total = rows * cols;
				if (total > OUT_LIMIT) begin
					total = OUT_LIMIT;
				end
				k = 0;
				for (int col = 0; col < cols && k < total; col++) begin
					for (int row = 0; row < rows && k < total; row++) begin
						pos = row * cols + col;
						add_expected(cipher_byte_t'{
							(pos < letter_cnt) ? letters[pos] : PAD_CHAR,
							k + 1 == total, 1'b0, lost_letters});
						k++;
					end
				end
			end
			letter_cnt = 0;
			lost_letters = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt = 0;
			rd_cnt = 0;
			letter_cnt = 0;
			lost_letters = 1'b0;
			errors = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_byte = '{m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]};
				if (wr_cnt == rd_cnt) begin
					$display("%0t: unexpected transfer, expected none, got char %h last %b empty %b ovf %b",
						$time, got_byte.text, got_byte.eom, got_byte.no_letters,
						got_byte.overflowed);
					errors++;
				end else begin
					want_byte = expect_mem[rd_cnt % EXP_DEPTH];
					rd_cnt++;
					if (got_byte !== want_byte) begin
						$display("%0t: mismatch, expected char %h last %b empty %b ovf %b",
							$time, want_byte.text, want_byte.eom, want_byte.no_letters,
							want_byte.overflowed);
						$display("%0t: mismatch, actual char %h last %b empty %b ovf %b",
							$time, got_byte.text, got_byte.eom, got_byte.no_letters,
							got_byte.overflowed);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				transpose_message(s_axis_tdata, s_axis_tlast);
			end
			pending = wr_cnt - rd_cnt;
		end
	end

endmodule

// ----- test/square_code_transposition_cipher_tb.sv -----
`timescale 1ns / 100ps
// Testbench top of the square code transposition cipher: it drives messages and
// output stalls and gives the verdict. Depends on sctc_pkg, the cipher and its checker.
module square_code_transposition_cipher_tb;
	import sctc_pkg::*;

	localparam int RANDOM_ITEMS = 350;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 200;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] char_in
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;            // [7:0] out_char
	logic       m_axis_tlast;
	logic [1:0] m_axis_tuser;            // [0] no_letters, [1] overflowed
	int         errors;
	int         pending;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         idle_cycles    = 0;

	always #5 clk = ~clk;

	square_code_transposition_cipher dut (.*);

	square_code_transposition_cipher_checker cipher_monitor (.*);

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] data, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tlast <= eom;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++) begin
			send_byte(txt[i], i == txt.len() - 1);
		end
	endtask

	initial begin
		int         sent;
		int         msg;
		int         len;
		int         pick;
		logic [7:0] data;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte("A", 1'b1);
		send_text("@[`{ZazA");
		send_text("Hi, Bo!");
		send_byte(8'h80, 1'b0);
		send_byte(8'hC1, 1'b0);
		send_byte(8'hE1, 1'b0);
		send_byte(8'hFA, 1'b1);

		sent = 0;
		msg = 0;
		while (sent < RANDOM_ITEMS) begin
			if (msg % 8 == 0) begin
				len = $urandom_range(75, 62);
			end else begin
				len = $urandom_range(12, 1);
			end
			if (len > RANDOM_ITEMS - sent) begin
				len = RANDOM_ITEMS - sent;
			end
			for (int i = 0; i < len; i++) begin
				case (sent * 4 / RANDOM_ITEMS)
					0: begin
						send_idle_pct = 0;
						recv_stall_pct = 0;
					end
					1: begin
						send_idle_pct = 45;
						recv_stall_pct = 0;
					end
					2: begin
						send_idle_pct = 0;
						recv_stall_pct = 45;
					end
					default: begin
						send_idle_pct = 20;
						recv_stall_pct = 20;
					end
				endcase
				pick = $urandom_range(99);
				if (pick < 45) begin
					data = 8'("a" + $urandom_range(25));
				end else if (pick < 85) begin
					data = 8'("A" + $urandom_range(25));
				end else begin
					data = 8'($urandom_range(255));
				end
				send_byte(data, i == len - 1);
				sent++;
			end
			msg++;
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
